@@ rtl/synthetic_order_flow_generator_assert.svh @@
// Assertion macros for the order-flow generator
`ifndef SYNTHETIC_ORDER_FLOW_GENERATOR_ASSERT_SVH
`define SYNTHETIC_ORDER_FLOW_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SOFG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sofg assertion failed");
`define SOFG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sofg assertion failed");
`else
`define SOFG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SOFG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sofg_pkg.sv @@
// Shared types and constants of the order-flow generator
`timescale 1ns / 1ps
package sofg_pkg;
    localparam int DATA_W  = 64;
    localparam int SPAN_W  = 21;
    localparam int DIGIT_W = 4;
    localparam int FAIR_W  = 34;
    localparam int PX_W    = 36;
    localparam int PRICE_W = 31;
    localparam int QTY_W   = 20;
    localparam int ID_W    = 48;
    localparam int TS_W    = 64;
    localparam int ADDR_W  = 6;
    localparam int PCT_W   = 7;

    localparam logic [DATA_W-1:0] SCRAMBLE = 64'h2545F4914F6CDD1D;
    localparam int SHIFT_A = 12;
    localparam int SHIFT_B = 25;
    localparam int SHIFT_C = 27;
    localparam int PCT_SPAN = 100;
    localparam int TRADE_QTY_SPAN = 200;

    localparam logic KIND_GEN     = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [2:0] {
        REG_SEED, REG_START_PRICE, REG_MIN_PRICE, REG_MAX_PRICE,
        REG_TICK_RANGE, REG_TICK_SIZE, REG_EVENT_MIX, REG_QTY_BOUNDS
    } t_reg_idx;

    typedef enum logic [1:0] {EVT_ADD, EVT_CANCEL, EVT_TRADE} t_evt_type;

    typedef enum logic [3:0] {
        S_IDLE, S_RNG, S_MOD, S_SNAP, S_BAND, S_RD0, S_RD1, S_WR, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        PH_WALK, PH_DIR, PH_ROLL, PH_SIDE, PH_QTY, PH_OFF, PH_CIDX, PH_TQTY
    } t_phase;

    typedef struct packed {
        logic load;
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic [PRICE_W-1:0] sat_price(input logic signed [PX_W-1:0] p);
        logic signed [PX_W-1:0] top;
        top = {{(PX_W-PRICE_W){1'b0}}, {PRICE_W{1'b1}}};
        if (p < 0) begin
            return '0;
        end else if (p > top) begin
            return {PRICE_W{1'b1}};
        end
        return p[PRICE_W-1:0];
    endfunction
endpackage

@@ rtl/sofg_req_if.sv @@
// Request channel of the order-flow generator
`timescale 1ns / 1ps
interface sofg_req_if import sofg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [TS_W-1:0] timestamp_ns;
    modport source(output valid, kind, timestamp_ns, input ready);
    modport sink(input valid, kind, timestamp_ns, output ready);
endinterface

@@ rtl/sofg_evt_if.sv @@
// Event channel of the order-flow generator
`timescale 1ns / 1ps
interface sofg_evt_if import sofg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [1:0]         event_type;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [ID_W-1:0]    order_ref;
    logic [ID_W-1:0]    sequence_res;
    logic [TS_W-1:0]    event_time_ns;
    modport source(output valid, valid_res, event_type, side, price, quantity, order_ref,
                   sequence_res, event_time_ns, input ready);
    modport sink(input valid, valid_res, event_type, side, price, quantity, order_ref,
                 sequence_res, event_time_ns, output ready);
endinterface

@@ rtl/synthetic_order_flow_generator.sv @@
// Top level of the synthetic order-flow generator
//
//  channel   | dir | handshake      | payload
//  i_req     | in  | valid/ready    | kind, timestamp_ns
//  o_evt     | out | valid/ready    | valid_res .. event_time_ns
//  apb       | in  | psel/penable   | paddr[5:3] register, pwdata 64 bits
//
//  One item at a time. A draw runs in the serial scramble multiplier,
//  a range reduction in the bit-serial modulo unit.
//  A generate item takes 5 to 6 draws and 4 to 5 reductions.
//  A restart item goes straight to the finish state. Reset needs no clearing pass.
//  A finished item waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`include "synthetic_order_flow_generator_assert.svh"
module synthetic_order_flow_generator import sofg_pkg::*; #(
    parameter int ID_STORE_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sofg_req_if.sink          i_req,
    sofg_evt_if.source        o_evt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    localparam int IW = (ID_STORE_DEPTH > 1) ? $clog2(ID_STORE_DEPTH) : 1;
    localparam int CW = $clog2(ID_STORE_DEPTH + 1);

    logic [63:0]        r_seed;
    logic [PRICE_W-1:0] r_start, r_min, r_max;
    logic [15:0]        r_trange, r_tsize;
    logic [20:0]        r_mix;
    logic [39:0]        r_qb;

    t_state                 r_state, n_state;
    t_phase                 r_ph, n_ph;
    logic signed [FAIR_W-1:0] r_fair;
    logic [ID_W-1:0]        r_cnt, r_nid, r_oid;
    logic [CW-1:0]          r_live;
    logic [PCT_W-1:0]       r_roll;
    logic                   r_buy, r_neg, r_restart;
    logic [QTY_W-1:0]       r_qty;
    logic signed [PX_W-1:0] r_price;
    logic [IW-1:0]          r_idx;
    logic [TS_W-1:0]        r_ts;
    t_evt_type              r_type;

    logic               r_ov, r_ovr, r_oside;
    logic [1:0]         r_otype;
    logic [PRICE_W-1:0] r_oprice;
    logic [QTY_W-1:0]   r_oqty;
    logic [ID_W-1:0]    r_ooid, r_oseq;
    logic [TS_W-1:0]    r_ots;

    t_unit_ctl         rng_ctl, mod_ctl;
    t_unit_sts         rng_sts, mod_sts;
    logic [DATA_W-1:0] rng_val, w_dvd;
    logic [SPAN_W-1:0] w_div, w_span, w_rem;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr, w_last;
    logic [ID_W-1:0]   ram_wdata, ram_rdata;

    logic [PCT_W-1:0]  w_pm, w_pa, w_pc;
    logic [QTY_W-1:0]  w_qmin, w_qmax;
    logic              w_is_add, w_is_can, w_out_free, w_fin, w_cfg_wr, w_has_room;
    logic signed [PX_W-1:0] w_fairx, w_px, w_mag, w_ts, w_lo, w_hi, w_walk;
    logic signed [PX_W-1:0] w_remf, w_snap, w_b1, w_band, w_minx, w_maxx, w_opx;

    assign w_pm   = r_mix[6:0];
    assign w_pa   = r_mix[13:7];
    assign w_pc   = r_mix[20:14];
    assign w_qmin = r_qb[19:0];
    assign w_qmax = r_qb[39:20];
    assign w_last = IW'(r_live - 1'b1);
    assign w_has_room = r_live < CW'(ID_STORE_DEPTH);

    assign w_is_add = (r_roll < w_pa) || (r_live == '0);
    assign w_is_can = {1'b0, r_roll} < ({1'b0, w_pa} + {1'b0, w_pc});

    assign w_fairx = {{(PX_W-FAIR_W){r_fair[FAIR_W-1]}}, r_fair};
    assign w_ts    = {{(PX_W-16){1'b0}}, r_tsize};
    assign w_minx  = {{(PX_W-PRICE_W){1'b0}}, r_min};
    assign w_maxx  = {{(PX_W-PRICE_W){1'b0}}, r_max};
    assign w_px    = r_buy ? w_fairx - PX_W'(w_rem) - PX_W'(1)
                           : w_fairx + PX_W'(w_rem) + PX_W'(1);
    assign w_mag   = (w_px < 0) ? -w_px : w_px;

    always_comb begin
        w_lo   = w_minx + {{(PX_W-16){1'b0}}, r_trange} + PX_W'(1);
        w_hi   = w_maxx - {{(PX_W-16){1'b0}}, r_trange} - PX_W'(1);
        w_walk = rng_val[0] ? w_fairx + PX_W'(1) : w_fairx - PX_W'(1);
        if (w_walk > w_hi) begin
            w_walk = w_hi;
        end
        if (w_walk < w_lo) begin
            w_walk = w_lo;
        end
    end

    always_comb begin
        if (!r_neg) begin
            w_remf = PX_W'(w_rem);
        end else if (w_rem == '0) begin
            w_remf = '0;
        end else begin
            w_remf = w_ts - PX_W'(w_rem);
        end
        if (w_remf == '0) begin
            w_snap = r_price;
        end else if (r_buy) begin
            w_snap = r_price - w_remf;
        end else begin
            w_snap = r_price + w_ts - w_remf;
        end
        w_b1   = (r_price < w_minx) ? r_price + w_ts : r_price;
        w_band = (w_b1 > w_maxx) ? w_b1 - w_ts : w_b1;
    end

    always_comb begin
        case (r_ph)
            PH_WALK, PH_ROLL: w_span = SPAN_W'(PCT_SPAN);
            PH_QTY:  w_span = (w_qmax >= w_qmin)
                            ? ({1'b0, w_qmax} - {1'b0, w_qmin} + SPAN_W'(1)) : SPAN_W'(1);
            PH_OFF:  w_span = (r_trange == '0) ? SPAN_W'(1) : SPAN_W'(r_trange);
            PH_CIDX: w_span = {{(SPAN_W-CW){1'b0}}, r_live};
            PH_TQTY: w_span = SPAN_W'(TRADE_QTY_SPAN);
            default: w_span = SPAN_W'(1);
        endcase
    end

    assign w_out_free = !r_ov || o_evt.ready;
    assign w_fin = (r_state == S_FIN) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) begin
                n_state = (i_req.kind == KIND_RESTART) ? S_FIN : S_RNG;
            end
            S_RNG: if (rng_sts.done && !(r_ph inside {PH_DIR, PH_SIDE})) begin
                n_state = S_MOD;
            end
            S_MOD: if (mod_sts.done) begin
                case (r_ph)
                    PH_OFF:  n_state = (r_tsize > 16'd1) ? S_SNAP : S_FIN;
                    PH_CIDX: n_state = S_RD0;
                    PH_TQTY: n_state = S_FIN;
                    default: n_state = S_RNG;
                endcase
            end
            S_SNAP:  if (mod_sts.done) n_state = S_BAND;
            S_BAND:  n_state = S_FIN;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_WR;
            S_WR:    n_state = S_FIN;
            S_FIN:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rng_ctl   = '0;
        mod_ctl   = '0;
        w_dvd     = rng_val;
        w_div     = w_span;
        n_ph      = r_ph;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx;
        case (r_state)
            S_IDLE: if (i_req.valid) begin
                if (i_req.kind == KIND_RESTART) begin
                    rng_ctl.load = 1'b1;
                end else begin
                    rng_ctl.start = 1'b1;
                    n_ph = PH_WALK;
                end
            end
            S_RNG: if (rng_sts.done) begin
                if (r_ph inside {PH_DIR, PH_SIDE}) begin
                    rng_ctl.start = 1'b1;
                    n_ph = (r_ph == PH_DIR) ? PH_ROLL : PH_QTY;
                end else begin
                    mod_ctl.start = 1'b1;
                end
            end
            S_MOD: if (mod_sts.done) begin
                case (r_ph)
                    PH_WALK: begin
                        rng_ctl.start = 1'b1;
                        n_ph = (w_rem < SPAN_W'(w_pm)) ? PH_DIR : PH_ROLL;
                    end
                    PH_ROLL: begin
                        rng_ctl.start = 1'b1;
                        n_ph = PH_SIDE;
                    end
                    PH_QTY: begin
                        rng_ctl.start = 1'b1;
                        n_ph = w_is_add ? PH_OFF : (w_is_can ? PH_CIDX : PH_TQTY);
                    end
                    PH_OFF: if (r_tsize > 16'd1) begin
                        mod_ctl.start = 1'b1;
                        w_dvd = {{(DATA_W-PX_W){1'b0}}, w_mag};
                        w_div = SPAN_W'(r_tsize);
                    end
                    default: ;
                endcase
            end
            S_RD1: ram_raddr = w_last;
            S_WR:  ram_we = 1'b1;
            S_FIN: if (w_out_free && !r_restart && r_type == EVT_ADD && w_has_room) begin
                ram_we    = 1'b1;
                ram_waddr = r_live[IW-1:0];
                ram_wdata = r_nid;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        case (r_type)
            EVT_ADD:    w_opx = r_price;
            EVT_TRADE:  w_opx = w_fairx;
            default:    w_opx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ph      <= PH_WALK;
            r_fair    <= FAIR_W'(10000);
            r_cnt     <= '0;
            r_nid     <= ID_W'(1);
            r_live    <= '0;
            r_restart <= 1'b0;
            r_type    <= EVT_ADD;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            if (r_state == S_IDLE && i_req.valid) begin
                r_ts      <= i_req.timestamp_ns;
                r_restart <= i_req.kind;
                if (i_req.kind == KIND_RESTART) begin
                    r_fair <= {{(FAIR_W-PRICE_W){1'b0}}, r_start};
                    r_cnt  <= '0;
                    r_nid  <= ID_W'(1);
                    r_live <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_RNG && rng_sts.done) begin
                if (r_ph == PH_DIR) r_fair <= w_walk[FAIR_W-1:0];
                if (r_ph == PH_SIDE) r_buy <= rng_val[0];
            end
            if (r_state == S_MOD && mod_sts.done) begin
                case (r_ph)
                    PH_ROLL: r_roll <= w_rem[PCT_W-1:0];
                    PH_QTY: begin
                        r_qty  <= w_qmin + w_rem[QTY_W-1:0];
                        r_type <= w_is_add ? EVT_ADD : (w_is_can ? EVT_CANCEL : EVT_TRADE);
                    end
                    PH_OFF: begin
                        r_price <= w_px;
                        r_neg   <= w_px < 0;
                    end
                    PH_CIDX: r_idx <= w_rem[IW-1:0];
                    PH_TQTY: r_qty <= QTY_W'(w_rem + SPAN_W'(1));
                    default: ;
                endcase
            end
            if (r_state == S_SNAP && mod_sts.done) r_price <= w_snap;
            if (r_state == S_BAND) r_price <= w_band;
            if (r_state == S_RD1) r_oid <= ram_rdata;
            if (r_state == S_WR) r_live <= r_live - 1'b1;
            if (r_ov && o_evt.ready && !w_fin) r_ov <= 1'b0;
            if (w_fin) begin
                r_ov <= 1'b1;
                if (r_restart) begin
                    r_ovr    <= 1'b0;
                    r_otype  <= '0;
                    r_oside  <= 1'b0;
                    r_oprice <= '0;
                    r_oqty   <= '0;
                    r_ooid   <= '0;
                    r_oseq   <= '0;
                    r_ots    <= '0;
                end else begin
                    r_ovr    <= 1'b1;
                    r_otype  <= r_type;
                    r_oside  <= !r_buy;
                    r_oprice <= sat_price(w_opx);
                    r_oqty   <= r_qty;
                    r_ooid   <= (r_type == EVT_CANCEL) ? r_oid : r_nid;
                    r_oseq   <= r_cnt;
                    r_ots    <= r_ts;
                    if (r_type != EVT_CANCEL) r_nid <= r_nid + 1'b1;
                    if (r_type == EVT_ADD && w_has_room) r_live <= r_live + 1'b1;
                end
            end
        end
    end

    assign o_evt.valid         = r_ov;
    assign o_evt.valid_res     = r_ovr;
    assign o_evt.event_type    = r_otype;
    assign o_evt.side          = r_oside;
    assign o_evt.price         = r_oprice;
    assign o_evt.quantity      = r_oqty;
    assign o_evt.order_ref     = r_ooid;
    assign o_evt.sequence_res  = r_oseq;
    assign o_evt.event_time_ns = r_ots;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= 64'd1;
            r_start  <= PRICE_W'(10000);
            r_min    <= '0;
            r_max    <= PRICE_W'(20000);
            r_trange <= 16'd10;
            r_tsize  <= 16'd1;
            r_mix    <= '0;
            r_qb     <= 40'd1048577;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[5:3]))
                REG_SEED:        r_seed   <= pwdata;
                REG_START_PRICE: r_start  <= pwdata[PRICE_W-1:0];
                REG_MIN_PRICE:   r_min    <= pwdata[PRICE_W-1:0];
                REG_MAX_PRICE:   r_max    <= pwdata[PRICE_W-1:0];
                REG_TICK_RANGE:  r_trange <= pwdata[15:0];
                REG_TICK_SIZE:   r_tsize  <= pwdata[15:0];
                REG_EVENT_MIX:   r_mix    <= pwdata[20:0];
                REG_QTY_BOUNDS:  r_qb     <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_SEED:        prdata = r_seed;
            REG_START_PRICE: prdata = 64'(r_start);
            REG_MIN_PRICE:   prdata = 64'(r_min);
            REG_MAX_PRICE:   prdata = 64'(r_max);
            REG_TICK_RANGE:  prdata = 64'(r_trange);
            REG_TICK_SIZE:   prdata = 64'(r_tsize);
            REG_EVENT_MIX:   prdata = 64'(r_mix);
            REG_QTY_BOUNDS:  prdata = 64'(r_qb);
            default:         prdata = '0;
        endcase
    end

    sofg_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rng_ctl),
        .i_seed  (r_seed),
        .o_sts   (rng_sts),
        .o_value (rng_val)
    );

    sofg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mod_ctl),
        .i_dividend (w_dvd),
        .i_divisor  (w_div),
        .o_sts      (mod_sts),
        .o_rem      (w_rem)
    );

    sofg_ram #(.WIDTH(ID_W), .DEPTH(ID_STORE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `SOFG_ASSERT_NXT(a_cancel_pops, i_clk, i_rst_n, r_state == S_WR, (r_live + 1'b1) == $past(r_live))
    `SOFG_ASSERT_IMP(a_rng_done_waits, i_clk, i_rst_n, rng_sts.done, r_state == S_RNG)
    `SOFG_ASSERT_IMP(a_store_room, i_clk, i_rst_n, ram_we && r_state == S_FIN, w_has_room)
endmodule

@@ rtl/sofg_ram.sv @@
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
module sofg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sofg_rng.sv @@
// Xorshift64* generator with a digit-serial scramble multiplier
`timescale 1ns / 1ps
module sofg_rng import sofg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_seed,
    output t_unit_sts         o_sts,
    output logic [DATA_W-1:0] o_value
);
    localparam int N_DIGITS = DATA_W / DIGIT_W;
    localparam int CNT_W = $clog2(N_DIGITS);

    logic [DATA_W-1:0] r_state, r_mc, r_sc, r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;
    logic [DATA_W-1:0] w_xs;
    logic [DATA_W+DIGIT_W-1:0] w_pp;

    always_comb begin
        w_xs = r_state ^ (r_state >> SHIFT_A);
        w_xs = w_xs ^ (w_xs << SHIFT_B);
        w_xs = w_xs ^ (w_xs >> SHIFT_C);
    end

    assign w_pp = r_mc * r_sc[DIGIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DATA_W'(1);
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(N_DIGITS - 1));
            if (i_ctl.load) begin
                r_state <= (i_seed == '0) ? DATA_W'(1) : i_seed;
            end else if (i_ctl.start) begin
                r_state <= w_xs;
                r_mc    <= w_xs;
                r_sc    <= SCRAMBLE;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + w_pp[DATA_W-1:0];
                r_mc  <= r_mc << DIGIT_W;
                r_sc  <= r_sc >> DIGIT_W;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_value    = r_acc;
endmodule

@@ rtl/sofg_mod.sv @@
// Bit-serial restoring modulo unit
`timescale 1ns / 1ps
module sofg_mod import sofg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [SPAN_W-1:0] i_divisor,
    output t_unit_sts         o_sts,
    output logic [SPAN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DATA_W);

    logic [SPAN_W-1:0] r_rem, r_div;
    logic [DATA_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;
    logic [SPAN_W:0]   w_t, w_d;

    assign w_t = {r_rem, r_dvd[DATA_W-1]};
    assign w_d = w_t - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DATA_W - 1));
            if (i_ctl.start) begin
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_dvd  <= i_dividend;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= (w_t >= {1'b0, r_div}) ? w_d[SPAN_W-1:0] : w_t[SPAN_W-1:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;
endmodule
